// ----- hdl/hpds_pkg.sv -----
package hpds_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned MagW     = 33;
  localparam int unsigned RadW     = 66;
  localparam int unsigned SqStages = 33;
  localparam int unsigned DivStages = 32;
  localparam int unsigned KW       = 31;
  localparam int unsigned ScoreW   = 48;
  localparam int unsigned RemW     = 49;
  localparam int unsigned ProdW    = 97;

  localparam logic CFG_REST_LENGTH     = 1'b0;
  localparam logic CFG_SPRING_CONSTANT = 1'b1;

  // Sideband that rides with an item through the square root and on to stage E.
  typedef struct packed {
    logic                   valid;
    logic                   want;
    logic [2:0]             dneg;
    logic [2:0][MagW-1:0]   amag;
  } pre_side_t;

  // Sideband that rides with an item through the force dividers.
  typedef struct packed {
    logic                   valid;
    logic                   fv;
    logic [2:0]             fneg;
    logic [2:0]             ovf;
    logic [ScoreW-1:0]      score;
  } post_side_t;

endpackage

// ----- hdl/hpds_sqrt.sv -----
module hpds_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hpds_pkg::RadW-1:0]     rad_i,
  output logic [hpds_pkg::MagW-1:0]     root_o
);

  localparam int unsigned N  = hpds_pkg::SqStages;
  localparam int unsigned RW = hpds_pkg::MagW + 3;

  logic [RW-1:0]                 rem_r  [N];
  logic [hpds_pkg::MagW-1:0]     root_r [N];
  logic [hpds_pkg::RadW-1:0]     rad_r  [N];
  logic [RW-1:0]                 rem_nxt  [N];
  logic [hpds_pkg::MagW-1:0]     root_nxt [N];
  logic [hpds_pkg::RadW-1:0]     rad_nxt  [N];

  // One result bit per stage: bring down two radicand bits, try root*4+1.
  always_comb begin
    logic [RW-1:0]             rem_in;
    logic [hpds_pkg::MagW-1:0] root_in;
    logic [hpds_pkg::RadW-1:0] rad_in;
    logic [RW-1:0]             t;
    logic [RW-1:0]             trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        rad_in  = rad_r[k-1];
      end
      t     = {rem_in[RW-3:0], rad_in[hpds_pkg::RadW-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      if (t >= trial) begin
        rem_nxt[k]  = t - trial;
        root_nxt[k] = {root_in[hpds_pkg::MagW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t;
        root_nxt[k] = {root_in[hpds_pkg::MagW-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_in[hpds_pkg::RadW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
      end
    end
  end

  assign root_o = root_r[N-1];

endmodule

// ----- hdl/hpds_div.sv -----
module hpds_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hpds_pkg::RemW-1:0]     rem_i,
  input  logic [31:0]                   low_i,
  input  logic [hpds_pkg::RemW-1:0]     dvs_i,
  output logic [31:0]                   q_o
);

  localparam int unsigned N = hpds_pkg::DivStages;

  logic [hpds_pkg::RemW-1:0] rem_r [N];
  logic [hpds_pkg::RemW-1:0] dvs_r [N];
  logic [31:0]               low_r [N];
  logic [31:0]               q_r   [N];
  logic [hpds_pkg::RemW-1:0] rem_nxt [N];
  logic [31:0]               low_nxt [N];
  logic [31:0]               q_nxt   [N];
  logic [hpds_pkg::RemW-1:0] dvs_in  [N];

  // Restoring division, one quotient bit per stage, remainder kept below the divisor.
  always_comb begin
    logic [hpds_pkg::RemW-1:0] rem_in;
    logic [31:0]               low_in;
    logic [31:0]               q_in;
    logic [hpds_pkg::RemW:0]   t;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in    = rem_i;
        low_in    = low_i;
        q_in      = '0;
        dvs_in[k] = dvs_i;
      end else begin
        rem_in    = rem_r[k-1];
        low_in    = low_r[k-1];
        q_in      = q_r[k-1];
        dvs_in[k] = dvs_r[k-1];
      end
      t = {rem_in, low_in[31]};
      if (t >= {1'b0, dvs_in[k]}) begin
        rem_nxt[k] = hpds_pkg::RemW'(t - {1'b0, dvs_in[k]});
        q_nxt[k]   = {q_in[30:0], 1'b1};
      end else begin
        rem_nxt[k] = t[hpds_pkg::RemW-1:0];
        q_nxt[k]   = {q_in[30:0], 1'b0};
      end
      low_nxt[k] = {low_in[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        q_r[k]   <= q_nxt[k];
        dvs_r[k] <= dvs_in[k];
      end
    end
  end

  assign q_o = q_r[N-1];

endmodule

// ----- hdl/harmonic_pair_distance_score_top.sv -----
// Harmonic pair score and force engine. Each input beat carries two particle
// positions in signed Q16.16; the matching output beat carries the score
// 0.5*k*(d-x0)^2 (unsigned Q32.16, saturating) and, when derivatives were
// requested and the positions differ, the force on the first particle
// (signed Q16.16 per axis, saturating, force_valid set). One beat is taken
// in every cycle that the output is not stalled. An item passes the
// difference, square, multiply and saturation stages, the 33-stage square
// root (one root bit per stage) and the 32-stage force dividers (one
// quotient bit per stage). The whole pipeline advances only when the output
// register is empty or being read, so a stall on the output holds every
// stage in place. The user must write rest_length and spring_constant via
// cfg only while no beat is in flight; the block does not enforce this.
module harmonic_pair_distance_score_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  logic [191:0] in_tdata,
  // want_derivatives
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // score (48), force_x (32), force_y (32), force_z (32)
  output logic [143:0] out_tdata,
  // force_valid
  output logic         out_tuser
);

  localparam int unsigned MW = hpds_pkg::MagW;
  localparam int unsigned SQ = hpds_pkg::SqStages;
  localparam int unsigned DV = hpds_pkg::DivStages;

  logic [30:0] x0_r;
  logic [30:0] k_r;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      k_r  <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpds_pkg::CFG_REST_LENGTH:     x0_r <= cfg_wdata;
        hpds_pkg::CFG_SPRING_CONSTANT: k_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 1: component differences as sign and magnitude.
  hpds_pkg::pre_side_t s1_r, s1_nxt;
  always_comb begin
    logic signed [MW-1:0] dl;
    s1_nxt.valid = in_tvalid;
    s1_nxt.want  = in_tuser;
    for (int i = 0; i < 3; i++) begin
      dl = $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]})
         - $signed({in_tdata[32*i+127], in_tdata[32*i+96 +: 32]});
      s1_nxt.dneg[i] = dl[MW-1];
      s1_nxt.amag[i] = dl[MW-1] ? MW'(-dl) : MW'(dl);
    end
  end

  // Stage 2: squares. Stage 3: sum of squares.
  hpds_pkg::pre_side_t s2_r, s3_r;
  logic [hpds_pkg::RadW-1:0] sq2_r [3];
  logic [hpds_pkg::RadW-1:0] d2_r;

  hpds_pkg::pre_side_t sqside_r [SQ];
  logic [MW-1:0] d_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      for (int k = 0; k < SQ; k++) sqside_r[k].valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
      sqside_r[0] <= s3_r;
      for (int k = 1; k < SQ; k++) sqside_r[k] <= sqside_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= hpds_pkg::RadW'(s1_r.amag[i]) * hpds_pkg::RadW'(s1_r.amag[i]);
      end
      d2_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    end
  end

  hpds_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (d2_r),
    .root_o (d_sq)
  );

  // Stage A: signed stretch s = d - x0.
  hpds_pkg::pre_side_t sa_r, sb_r, sc_r, sd_r;
  logic [MW-1:0] da_r, db_r, dc_r, dd_r;
  logic          sneg_a_r, sneg_b_r, sneg_c_r, sneg_d_r;
  logic [MW-1:0] smag_a_r;
  logic signed [MW:0] s_diff;
  assign s_diff = $signed({1'b0, d_sq}) - $signed({3'b000, x0_r});

  // Stage B: s^2 and k*|s|.
  logic [hpds_pkg::RadW-1:0] s2_b_r;
  logic [63:0]               m_b_r;
  // Stage C: partial products.
  logic [63:0]               pl_c_r, ph_c_r;
  logic [64:0]               nl_c_r [3];
  logic [64:0]               nh_c_r [3];
  // Stage D: full products.
  logic [hpds_pkg::ProdW-1:0] p_d_r;
  logic [hpds_pkg::ProdW-1:0] n_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.valid <= 1'b0;
      sb_r.valid <= 1'b0;
      sc_r.valid <= 1'b0;
      sd_r.valid <= 1'b0;
    end else if (en) begin
      sa_r <= sqside_r[SQ-1];
      sb_r <= sa_r;
      sc_r <= sb_r;
      sd_r <= sc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r     <= d_sq;
      sneg_a_r <= s_diff[MW];
      smag_a_r <= s_diff[MW] ? MW'(-s_diff) : MW'(s_diff);

      db_r     <= da_r;
      sneg_b_r <= sneg_a_r;
      s2_b_r   <= hpds_pkg::RadW'(smag_a_r) * hpds_pkg::RadW'(smag_a_r);
      m_b_r    <= 64'(smag_a_r) * 64'(k_r);

      dc_r     <= db_r;
      sneg_c_r <= sneg_b_r;
      pl_c_r   <= 64'(s2_b_r[32:0]) * 64'(k_r);
      ph_c_r   <= 64'(s2_b_r[65:33]) * 64'(k_r);
      for (int i = 0; i < 3; i++) begin
        nl_c_r[i] <= 65'(m_b_r[31:0]) * 65'(sb_r.amag[i]);
        nh_c_r[i] <= 65'(m_b_r[63:32]) * 65'(sb_r.amag[i]);
      end

      dd_r     <= dc_r;
      sneg_d_r <= sneg_c_r;
      p_d_r    <= (hpds_pkg::ProdW'(ph_c_r) << 33) + hpds_pkg::ProdW'(pl_c_r);
      for (int i = 0; i < 3; i++) begin
        n_d_r[i] <= (hpds_pkg::ProdW'(nh_c_r[i]) << 32) + hpds_pkg::ProdW'(nl_c_r[i]);
      end
    end
  end

  // Stage E: score saturation, quotient overflow test, divider setup.
  hpds_pkg::post_side_t se_r, se_nxt;
  logic [hpds_pkg::RemW-1:0] rem_e_r [3];
  logic [31:0]               low_e_r [3];
  logic [hpds_pkg::RemW-1:0] dvs_e_r;

  always_comb begin
    se_nxt.valid = sd_r.valid;
    se_nxt.fv    = sd_r.want && (dd_r != '0);
    se_nxt.score = (p_d_r[96:81] != '0) ? {hpds_pkg::ScoreW{1'b1}} : p_d_r[80:33];
    for (int i = 0; i < 3; i++) begin
      se_nxt.fneg[i] = sneg_d_r ^ sd_r.dneg[i];
      se_nxt.ovf[i]  = n_d_r[i][96:48] >= hpds_pkg::RemW'(dd_r);
    end
  end

  hpds_pkg::post_side_t dvside_r [DV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_r.valid <= 1'b0;
      for (int k = 0; k < DV; k++) dvside_r[k].valid <= 1'b0;
    end else if (en) begin
      se_r        <= se_nxt;
      dvside_r[0] <= se_r;
      for (int k = 1; k < DV; k++) dvside_r[k] <= dvside_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_e_r <= {dd_r, 16'h0000};
      for (int i = 0; i < 3; i++) begin
        // Only meaningful when the quotient does not overflow 32 bits.
        rem_e_r[i] <= n_d_r[i][80:32];
        low_e_r[i] <= n_d_r[i][31:0];
      end
    end
  end

  logic [31:0] q [3];
  for (genvar g = 0; g < 3; g++) begin : g_div
    hpds_div u_div (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_e_r[g]),
      .low_i (low_e_r[g]),
      .dvs_i (dvs_e_r),
      .q_o   (q[g])
    );
  end

  // Output register: saturate each force to 32 bits and apply its sign.
  logic [143:0] out_data_r;
  logic         out_fv_r;
  logic [95:0]  force_nxt;

  always_comb begin
    hpds_pkg::post_side_t f;
    logic big;
    f = dvside_r[DV-1];
    for (int i = 0; i < 3; i++) begin
      big = f.ovf[i] || q[i][31];
      if (!f.fv) begin
        force_nxt[32*i +: 32] = '0;
      end else if (f.fneg[i]) begin
        force_nxt[32*i +: 32] = big ? 32'h8000_0000 : 32'(-q[i]);
      end else begin
        force_nxt[32*i +: 32] = big ? 32'h7FFF_FFFF : q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dvside_r[DV-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {force_nxt, dvside_r[DV-1].score};
      out_fv_r   <= dvside_r[DV-1].fv;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fv_r;

endmodule
